/* hdl/ffha_pkg.sv */
// Package for the first-fit heap allocator: constants, payload structs, codes.
// No dependencies.
package ffha_pkg;
  localparam int MaxBlocks = 64;
  localparam int SlotBits = $clog2(MaxBlocks);
  localparam int CntBits = $clog2(MaxBlocks + 1);
  localparam int HeaderBytes = 40;
  localparam int AlignBytes = 8;
  localparam int AlignBits = 3;
  localparam int MinSplitSlack = 16;
  localparam int OffsetBits = 20;
  localparam int SizeBits = OffsetBits + 2;
  localparam int UsedBits = 21;
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegHeapBase = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegHeapSize = 1'd1;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatOom = 2'd2;
  localparam logic [1:0] StatBadFree = 2'd3;
  localparam logic FuncAlloc = 1'b0;

  typedef struct packed {
    logic        func;
    logic [20:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
    logic [20:0] used_total;
  } rsp_t;

  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [OffsetBits-1:0] size;
    logic                  free;
    logic [SlotBits-1:0]   next;
    logic [SlotBits-1:0]   prev;
    logic                  has_next;
    logic                  has_prev;
  } entry_t;
endpackage

/* hdl/ffha_table.sv */
// Block table memory: one read port, one write port, registered read data.
// Depends on ffha_pkg.
module ffha_table (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ffha_pkg::SlotBits-1:0] waddr,
  input  ffha_pkg::entry_t             wdata,
  input  logic [ffha_pkg::SlotBits-1:0] raddr,
  output ffha_pkg::entry_t             rdata
);
  ffha_pkg::entry_t mem [ffha_pkg::MaxBlocks];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/first_fit_heap_allocator_top.sv */
// First-fit heap allocator with coalescing, top level with sequencer.
// Depends on ffha_pkg and ffha_table.
//
// Usage: drive func/request_size/free_address on req and raise start while
// busy is low. The transfer happens on that edge; busy stays high until the
// result appears on rsp for one cycle with done high. The receiver cannot
// stall; every result is taken in its cycle.
// Every step goes through the block table (one read port, one write port);
// each block visited on the walk costs a read state and a check state. A
// miss answers after the walk; a grant adds a used-count update, a split
// adds writing the new block and relinking the old successor, and a free
// reads the next and the previous neighbor and merges each one that is free.
// A zero-size request answers without a walk. One item at a time, and the
// next start can be taken at the edge that takes the result.
// The table memory holds no reset: slot zero is rewritten right after reset
// or a register write (busy high). Reset loads heap_base 0,
// heap_size 65536 and clears the used count.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
module first_fit_heap_allocator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  ffha_pkg::req_t                       req,
  output logic                                 busy,
  output logic                                 done,
  output ffha_pkg::rsp_t                       rsp,
  input  logic                                 cfg_we,
  input  logic [ffha_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [31:0]                          cfg_data
);
  typedef enum logic [12:0] {
    S_INIT   = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_RD     = 13'b0000000000100,
    S_CHK    = 13'b0000000001000,
    S_SPLIT  = 13'b0000000010000,
    S_LRD    = 13'b0000000100000,
    S_LWR    = 13'b0000001000000,
    S_FRN    = 13'b0000010000000,
    S_FRN2   = 13'b0000100000000,
    S_FRP    = 13'b0001000000000,
    S_FRP2   = 13'b0010000000000,
    S_FNX    = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  localparam int SB = ffha_pkg::SlotBits;
  localparam int OB = ffha_pkg::OffsetBits;
  localparam int ZB = ffha_pkg::SizeBits;

  state_t state;
  state_t lret;
  logic [31:0] heap_base;
  logic [20:0] heap_size;
  logic [20:0] used;
  logic        func;
  logic [ZB-1:0] need;
  logic [31:0] faddr;
  logic [SB-1:0] cur;
  logic [ffha_pkg::CntBits-1:0] steps;
  logic [ffha_pkg::MaxBlocks-1:0] in_use;
  ffha_pkg::entry_t ce;
  ffha_pkg::entry_t ne;
  logic [SB-1:0] nslot;
  logic [SB-1:0] other;
  logic [SB-1:0] lprev;
  logic [1:0] status;
  logic [31:0] out_addr;
  logic        dirty;
  logic [31:0] rsp_addr;
  logic [1:0]  rsp_stat;

  logic we;
  logic [SB-1:0] waddr, raddr;
  ffha_pkg::entry_t wdata, rdata;

  ffha_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // spare slot pick
  logic spare_ok;
  logic [SB-1:0] spare;
  always_comb begin
    spare_ok = 1'b0;
    spare = '0;
    for (int i = ffha_pkg::MaxBlocks - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        spare_ok = 1'b1;
        spare = SB'(i);
      end
    end
  end

  logic [20:0] capped;
  logic [ZB-1:0] rsz;
  logic [31:0] paddr;
  logic [ZB-1:0] blk_total;
  logic [21:0] used_add;
  assign capped = (heap_size > 21'(1 << OB)) ? 21'(1 << OB) : heap_size;
  assign rsz = ZB'(req.request_size) + ZB'(ffha_pkg::AlignBytes - 1);
  assign paddr = heap_base + 32'(rdata.offset) + 32'(ffha_pkg::HeaderBytes);
  assign blk_total = ZB'(ce.size) + ZB'(ffha_pkg::HeaderBytes);
  assign used_add = 22'(used) + 22'(blk_total);

  // entry images for the table writes
  ffha_pkg::entry_t init_e, ce_chk, ne_new, ce_split, ce_mrg, pv_mrg, lnk_e;
  always_comb begin
    init_e = '0;
    init_e.free = 1'b1;
    init_e.size = (capped >= 21'(ffha_pkg::HeaderBytes))
                  ? OB'(capped - 21'(ffha_pkg::HeaderBytes)) : '0;
    ce_chk = rdata;
    ce_chk.free = (func != ffha_pkg::FuncAlloc);
    ne_new.offset = OB'(ZB'(rdata.offset) + ZB'(ffha_pkg::HeaderBytes) + need);
    ne_new.size = OB'(ZB'(rdata.size) - need - ZB'(ffha_pkg::HeaderBytes));
    ne_new.free = 1'b1;
    ne_new.next = rdata.next;
    ne_new.prev = cur;
    ne_new.has_next = rdata.has_next;
    ne_new.has_prev = 1'b1;
    ce_split = ce;
    ce_split.next = nslot;
    ce_split.has_next = 1'b1;
    ce_split.size = OB'(need);
    ce_split.free = 1'b0;
    ce_mrg = ce;
    ce_mrg.size = OB'(ZB'(ce.size) + ZB'(ffha_pkg::HeaderBytes) + ZB'(rdata.size));
    ce_mrg.next = rdata.next;
    ce_mrg.has_next = rdata.has_next;
    pv_mrg = rdata;
    pv_mrg.size = OB'(ZB'(rdata.size) + ZB'(ffha_pkg::HeaderBytes) + ZB'(ce.size));
    pv_mrg.next = ce.next;
    pv_mrg.has_next = ce.has_next;
    lnk_e = rdata;
    lnk_e.prev = lprev;
  end

  always_comb begin
    we = 1'b0;
    waddr = cur;
    wdata = ce;
    raddr = cur;
    case (state)
      S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata = init_e;
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = nslot;
        wdata = ne;
      end
      S_LRD, S_FRN: raddr = other;
      S_LWR: begin
        we = 1'b1;
        waddr = other;
        wdata = lnk_e;
      end
      S_FRP: raddr = ce.prev;
      S_FRP2: begin
        we = rdata.free;
        waddr = ce.prev;
        wdata = pv_mrg;
      end
      S_DONE: we = dirty;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= !rst && !cfg_we && (state == S_DONE);
    if (rst) begin
      state <= S_INIT;
      heap_base <= '0;
      heap_size <= 21'd65536;
      used <= '0;
      in_use <= '0;
      dirty <= 1'b0;
      rsp_addr <= '0;
      rsp_stat <= ffha_pkg::StatOk;
    end else if (cfg_we) begin
      if (cfg_index == ffha_pkg::RegHeapBase) heap_base <= cfg_data;
      else heap_size <= cfg_data[20:0];
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT: begin
          in_use <= ffha_pkg::MaxBlocks'(1);
          used <= '0;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            func <= req.func;
            need <= {rsz[ZB-1:ffha_pkg::AlignBits], ffha_pkg::AlignBits'(0)};
            faddr <= req.free_address;
            cur <= '0;
            steps <= '0;
            out_addr <= '0;
            dirty <= 1'b0;
            if (req.func == ffha_pkg::FuncAlloc && req.request_size == '0) begin
              status <= ffha_pkg::StatZero;
              state <= S_DONE;
            end else begin
              status <= ffha_pkg::StatOk;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          ce <= ce_chk;
          steps <= steps + 1'b1;
          if (func == ffha_pkg::FuncAlloc) begin
            if (rdata.free && ZB'(rdata.size) >= need) begin
              out_addr <= paddr;
              dirty <= 1'b1;
              if (ZB'(rdata.size) >= need + ZB'(ffha_pkg::HeaderBytes + ffha_pkg::MinSplitSlack)
                  && spare_ok) begin
                nslot <= spare;
                in_use[spare] <= 1'b1;
                ne <= ne_new;
                state <= S_SPLIT;
              end else begin
                state <= S_FNX; // finish: used update
              end
            end else if (!rdata.has_next || steps == ffha_pkg::CntBits'(ffha_pkg::MaxBlocks - 1)) begin
              status <= ffha_pkg::StatOom;
              state <= S_DONE;
            end else begin
              cur <= rdata.next;
              state <= S_RD;
            end
          end else begin
            if (paddr == faddr) begin
              if (rdata.free) begin
                status <= ffha_pkg::StatBadFree;
                state <= S_DONE;
              end else begin
                dirty <= 1'b1;
                if (used >= 21'(ZB'(rdata.size) + ZB'(ffha_pkg::HeaderBytes)))
                  used <= used - 21'(ZB'(rdata.size) + ZB'(ffha_pkg::HeaderBytes));
                other <= rdata.next;
                state <= rdata.has_next ? S_FRN : S_FRP;
              end
            end else if (!rdata.has_next || steps == ffha_pkg::CntBits'(ffha_pkg::MaxBlocks - 1)) begin
              status <= (faddr == '0) ? ffha_pkg::StatOk : ffha_pkg::StatBadFree;
              state <= S_DONE;
            end else begin
              cur <= rdata.next;
              state <= S_RD;
            end
          end
        end
        S_SPLIT: begin
          ce <= ce_split;
          if (ne.has_next) begin
            other <= ne.next;
            lprev <= nslot;
            lret <= S_FNX;
            state <= S_LRD;
          end else begin
            state <= S_FNX;
          end
        end
        // relink: prev of slot other becomes lprev
        S_LRD: state <= S_LWR;
        S_LWR: state <= lret;
        S_FRN: state <= S_FRN2;
        S_FRN2: begin
          // rdata = next block
          if (rdata.free) begin
            ce <= ce_mrg;
            in_use[other] <= 1'b0;
            if (rdata.has_next) begin
              other <= rdata.next;
              lprev <= cur;
              lret <= S_FRP;
              state <= S_LRD;
            end else begin
              state <= S_FRP;
            end
          end else begin
            state <= S_FRP;
          end
        end
        S_FRP: state <= ce.has_prev ? S_FRP2 : S_DONE;
        S_FRP2: begin
          // rdata = previous block
          if (rdata.free) begin
            in_use[cur] <= 1'b0;
            if (ce.has_next) begin
              other <= ce.next;
              lprev <= ce.prev;
              lret <= S_DONE;
              state <= S_LRD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_FNX: begin
          used <= (used_add > 22'((1 << ffha_pkg::UsedBits) - 1))
                  ? 21'((1 << ffha_pkg::UsedBits) - 1) : used_add[20:0];
          state <= S_DONE;
        end
        S_DONE: begin
          rsp_addr <= out_addr;
          rsp_stat <= status;
          state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign rsp = {rsp_addr, rsp_stat, used};
endmodule

/* hdl/ffha_checker.sv */
// Port-level checker for the heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_top.
module ffha_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input ffha_pkg::rsp_t rsp
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> !$past(busy) == 1'b0)
    else $error("result without busy");
  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ffha_pkg::StatOk |-> rsp.address == 32'd0)
    else $error("address on failure");
  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("transfer not taken");
endmodule

bind first_fit_heap_allocator_top ffha_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

/* dv/tb_top.sv */
// Testbench for first_fit_heap_allocator_top: directed table, then random allocate/free traffic.
// It keeps its own copy of the block table; each result is checked against it or a typed row.
// Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  localparam int UsedMax = 2097151;
  localparam int CycleLimit = 2000000;

  logic clk;
  logic rst;
  logic start;
  ffha_pkg::req_t req;
  logic busy;
  logic done;
  ffha_pkg::rsp_t rsp;
  logic cfg_we;
  logic [ffha_pkg::CfgIdxBits-1:0] cfg_index;
  logic [31:0] cfg_data;

  first_fit_heap_allocator_top u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // heap table copy
  logic [31:0] heap_base_q;
  int unsigned heap_size_q;
  int unsigned blk_off[ffha_pkg::MaxBlocks];
  int unsigned blk_size[ffha_pkg::MaxBlocks];
  bit blk_free[ffha_pkg::MaxBlocks];
  int blk_next[ffha_pkg::MaxBlocks];
  int blk_prev[ffha_pkg::MaxBlocks];
  bit blk_has_next[ffha_pkg::MaxBlocks];
  bit blk_has_prev[ffha_pkg::MaxBlocks];
  bit slot_busy[ffha_pkg::MaxBlocks];
  int unsigned bytes_used;

  ffha_pkg::rsp_t expected_rsp[$];
  logic [31:0] live_addr[$];
  logic [31:0] last_freed;
  int errors;
  int results_seen;
  int n_alloc_ok, n_oom, n_bad_free, n_free_ok;
  int cycles;

  function automatic void table_reset();
    int unsigned total;
    total = (heap_size_q > (1 << ffha_pkg::OffsetBits)) ? (1 << ffha_pkg::OffsetBits)
                                                         : heap_size_q;
    for (int i = 0; i < ffha_pkg::MaxBlocks; i++) begin
      blk_off[i] = 0; blk_size[i] = 0; blk_free[i] = 0; blk_next[i] = 0;
      blk_prev[i] = 0; blk_has_next[i] = 0; blk_has_prev[i] = 0; slot_busy[i] = 0;
    end
    slot_busy[0] = 1;
    blk_free[0] = 1;
    blk_size[0] = (total >= ffha_pkg::HeaderBytes) ? total - ffha_pkg::HeaderBytes : 0;
    bytes_used = 0;
  endfunction

  function automatic logic [31:0] payload_of(int s);
    return heap_base_q + 32'(blk_off[s]) + 32'(ffha_pkg::HeaderBytes);
  endfunction

  function automatic ffha_pkg::rsp_t heap_step(ffha_pkg::req_t r);
    ffha_pkg::rsp_t o;
    int cur;
    int n;
    int unsigned rq;
    bit found;
    o = '0;
    cur = 0;
    found = 0;
    if (r.func == ffha_pkg::FuncAlloc) begin
      rq = r.request_size;
      if (rq == 0) begin
        o.status = ffha_pkg::StatZero;
        o.used_total = bytes_used[20:0];
        return o;
      end
      rq = (rq + ffha_pkg::AlignBytes - 1) / ffha_pkg::AlignBytes * ffha_pkg::AlignBytes;
      o.status = ffha_pkg::StatOom;
      for (int steps = 0; steps < ffha_pkg::MaxBlocks; steps++) begin
        if (blk_free[cur] && blk_size[cur] >= rq) begin
          if (blk_size[cur] >= rq + ffha_pkg::HeaderBytes + ffha_pkg::MinSplitSlack) begin
            n = -1;
            for (int i = ffha_pkg::MaxBlocks - 1; i >= 0; i--) if (!slot_busy[i]) n = i;
            if (n >= 0) begin
              slot_busy[n] = 1;
              blk_off[n] = blk_off[cur] + ffha_pkg::HeaderBytes + rq;
              blk_size[n] = blk_size[cur] - rq - ffha_pkg::HeaderBytes;
              blk_free[n] = 1;
              blk_next[n] = blk_next[cur];
              blk_has_next[n] = blk_has_next[cur];
              blk_prev[n] = cur;
              blk_has_prev[n] = 1;
              if (blk_has_next[cur]) blk_prev[blk_next[cur]] = n;
              blk_next[cur] = n;
              blk_has_next[cur] = 1;
              blk_size[cur] = rq;
            end
          end
          blk_free[cur] = 0;
          bytes_used += blk_size[cur] + ffha_pkg::HeaderBytes;
          if (bytes_used > UsedMax) bytes_used = UsedMax;
          o.address = payload_of(cur);
          o.status = ffha_pkg::StatOk;
          break;
        end
        if (!blk_has_next[cur]) break;
        cur = blk_next[cur];
      end
    end else begin
      for (int steps = 0; steps < ffha_pkg::MaxBlocks; steps++) begin
        if (payload_of(cur) == r.free_address) begin
          found = 1;
          break;
        end
        if (!blk_has_next[cur]) break;
        cur = blk_next[cur];
      end
      if (!found || blk_free[cur]) begin
        o.status = (r.free_address == 0 && !found) ? ffha_pkg::StatOk : ffha_pkg::StatBadFree;
      end else begin
        blk_free[cur] = 1;
        if (bytes_used >= blk_size[cur] + ffha_pkg::HeaderBytes)
          bytes_used -= blk_size[cur] + ffha_pkg::HeaderBytes;
        if (blk_has_next[cur] && blk_free[blk_next[cur]]) begin
          n = blk_next[cur];
          blk_size[cur] += ffha_pkg::HeaderBytes + blk_size[n];
          blk_next[cur] = blk_next[n];
          blk_has_next[cur] = blk_has_next[n];
          if (blk_has_next[cur]) blk_prev[blk_next[cur]] = cur;
          slot_busy[n] = 0;
        end
        if (blk_has_prev[cur] && blk_free[blk_prev[cur]]) begin
          n = blk_prev[cur];
          blk_size[n] += ffha_pkg::HeaderBytes + blk_size[cur];
          blk_next[n] = blk_next[cur];
          blk_has_next[n] = blk_has_next[cur];
          if (blk_has_next[cur]) blk_prev[blk_next[cur]] = n;
          slot_busy[cur] = 0;
        end
        o.status = ffha_pkg::StatOk;
      end
    end
    o.used_total = bytes_used[20:0];
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      ffha_pkg::rsp_t e;
      results_seen++;
      if (expected_rsp.size() == 0) begin
        $error("result with nothing expected: %h", rsp);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.address !== e.address) begin
          $error("address exp %h got %h", e.address, rsp.address);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.used_total !== e.used_total) begin
          $error("used_total exp %0d got %0d", e.used_total, rsp.used_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  int gap_pct;

  task automatic send_item(ffha_pkg::req_t r, bit typed, ffha_pkg::rsp_t typed_rsp);
    ffha_pkg::rsp_t p;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    p = heap_step(r);
    expected_rsp.push_back(typed ? typed_rsp : p);
    if (r.func == ffha_pkg::FuncAlloc) begin
      if (p.status == ffha_pkg::StatOk) begin
        live_addr.push_back(p.address);
        n_alloc_ok++;
      end else if (p.status == ffha_pkg::StatOom) n_oom++;
    end else begin
      if (p.status == ffha_pkg::StatBadFree) n_bad_free++;
      else n_free_ok++;
    end
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [ffha_pkg::CfgIdxBits-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == ffha_pkg::RegHeapBase) heap_base_q = val;
    else heap_size_q = val[20:0];
    table_reset();
    live_addr.delete();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  typedef struct {
    logic           func;
    logic [20:0]    size;
    logic [31:0]    addr;
    bit             typed;
    ffha_pkg::rsp_t exp_rsp;
  } row_t;

  localparam logic FuncAlloc = ffha_pkg::FuncAlloc;
  localparam logic FuncFree = ~ffha_pkg::FuncAlloc;
  localparam logic [1:0] StatOk = ffha_pkg::StatOk;
  localparam logic [1:0] StatZero = ffha_pkg::StatZero;
  localparam logic [1:0] StatOom = ffha_pkg::StatOom;
  localparam logic [1:0] StatBadFree = ffha_pkg::StatBadFree;

  row_t rows[] = '{
    '{FuncAlloc, 21'd0, 32'd0, 1, '{32'd0, StatZero, 21'd0}},
    '{FuncAlloc, 21'h1FFFFF, 32'd0, 1, '{32'd0, StatOom, 21'd0}},
    '{FuncAlloc, 21'd1, 32'd0, 1, '{32'd40, StatOk, 21'd48}},
    '{FuncFree, 21'd0, 32'd40, 1, '{32'd0, StatOk, 21'd0}},
    '{FuncFree, 21'd0, 32'd40, 1, '{32'd0, StatBadFree, 21'd0}},
    '{FuncFree, 21'd0, 32'd0, 1, '{32'd0, StatOk, 21'd0}},
    '{FuncFree, 21'h1FFFFF, 32'hFFFFFFFF, 1, '{32'd0, StatBadFree, 21'd0}},
    '{FuncAlloc, 21'd65496, 32'd0, 1, '{32'd40, StatOk, 21'd65536}},
    '{FuncAlloc, 21'd8, 32'd0, 1, '{32'd0, StatOom, 21'd65536}},
    '{FuncFree, 21'd0, 32'd40, 1, '{32'd0, StatOk, 21'd0}},
    '{FuncAlloc, 21'd100, 32'd0, 0, '0},
    '{FuncAlloc, 21'd17, 32'd0, 0, '0},
    '{FuncAlloc, 21'd8, 32'd0, 0, '0},
    '{FuncAlloc, 21'd65000, 32'd0, 0, '0},
    '{FuncFree, 21'd0, 32'd184, 0, '0},
    '{FuncFree, 21'd0, 32'd184, 0, '0},
    '{FuncFree, 21'd0, 32'd40, 0, '0},
    '{FuncFree, 21'd0, 32'd248, 0, '0},
    '{FuncAlloc, 21'd64, 32'd0, 0, '0},
    '{FuncFree, 21'd0, 32'd41, 0, '0}
  };

  task automatic random_items(int count, int size_cap);
    ffha_pkg::req_t r;
    int k;
    for (int i = 0; i < count; i++) begin
      r = '0;
      r.request_size = 21'($urandom);
      r.free_address = $urandom;
      k = $urandom_range(99);
      if (k < 55) begin
        r.func = FuncAlloc;
        if ($urandom_range(19) == 0) r.request_size = 21'($urandom);
        else if ($urandom_range(29) == 0) r.request_size = 0;
        else r.request_size = 21'($urandom_range(1, size_cap));
      end else begin
        r.func = FuncFree;
        if (k < 88 && live_addr.size() != 0) begin
          int j;
          j = $urandom_range(live_addr.size() - 1);
          r.free_address = live_addr[j];
          last_freed = live_addr[j];
          live_addr.delete(j);
        end else if (k < 93) begin
          r.free_address = last_freed;
        end else if (k < 95) begin
          r.free_address = 32'd0;
        end
      end
      send_item(r, 1'b0, '0);
    end
  endtask

  initial begin
    ffha_pkg::req_t r;
    logic [31:0] bases[6];
    int unsigned sizes[6];
    int caps[6];
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    last_freed = 0;
    heap_base_q = 0;
    heap_size_q = 65536;
    table_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 18;
    foreach (rows[i]) begin
      r.func = rows[i].func;
      r.request_size = rows[i].size;
      r.free_address = rows[i].addr;
      send_item(r, rows[i].typed, rows[i].exp_rsp);
    end

    bases = '{32'd0, 32'hFFFFFFF0, $urandom, 32'h1000, $urandom, 32'hFFFFFFFF};
    sizes = '{65536, 2097151, 64, 4096, 1048576, 32};
    caps = '{1500, 30000, 40, 300, 3000, 64};
    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 18 : (ph < 4) ? 51 : 0;
      quiesce();
      write_reg(ffha_pkg::RegHeapBase, bases[ph]);
      write_reg(ffha_pkg::RegHeapSize, sizes[ph]);
      random_items((ph == 5) ? 60 : 360, caps[ph]);
    end

    quiesce();
    $display("covered %0d results: %0d grants, %0d out of memory, %0d frees, %0d bad frees",
             results_seen, n_alloc_ok, n_oom, n_free_ok, n_bad_free);
    $display("six heap settings, base and size extremes, three sender gap rates");
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
